// File: rtl/core/rsb_pkg.sv
package rsb_pkg;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 200;
  localparam int DEF_ROW_BACKSTEP  = 12;

  // position register width, wide enough for the saturation bounds
  localparam int POS_W     = 24;
  localparam int POS_LIMIT = 4194304;
  // widest framebuffer index (1024 x 1024 entries)
  localparam int ADDR_W    = 20;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic [7:0] END_MARK = 8'h0F;

  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_AVG    = 2'd1;
  localparam logic [1:0] MODE_SHADOW = 2'd2;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef logic signed [POS_W-1:0] pos_t;

  localparam logic signed [POS_W:0] SUM_HI = (POS_W+1)'(POS_LIMIT);
  localparam logic signed [POS_W:0] SUM_LO = -SUM_HI;

  // request from the stream control into the framebuffer pipeline
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [1:0]        mode;
    logic [7:0]        src;
    logic [ADDR_W-1:0] addr;
  } req_t;

  // one result item leaving the framebuffer pipeline
  typedef struct packed {
    kind_t       kind;
    logic [15:0] addr;
    logic [7:0]  value;
  } res_t;

  function automatic pos_t pos_add(pos_t p, pos_t d);
    logic signed [POS_W:0] s;
    s = {p[POS_W-1], p} + {d[POS_W-1], d};
    if (s > SUM_HI) begin
      s = SUM_HI;
    end else if (s < SUM_LO) begin
      s = SUM_LO;
    end
    return POS_W'(s);
  endfunction

endpackage

// File: rtl/core/rsb_frame.sv
module rsb_frame #(
  parameter int SCREEN_WIDTH  = rsb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = rsb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic          clk,
  input  logic          rst,
  input  rsb_pkg::req_t req,
  input  logic          adv,
  output logic          s1_valid,
  output rsb_pkg::res_t res,
  output logic          clearing
);
  import rsb_pkg::*;

  localparam int FB_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW       = $clog2(FB_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(FB_DEPTH - 1);

  logic [7:0] mem [FB_DEPTH];

  logic [AW-1:0] clr_cnt;
  logic          load;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rdata;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  kind_t         s1_kind;
  logic [1:0]    s1_mode;
  logic [7:0]    s1_src;
  logic [AW-1:0] s1_addr;
  logic          byp_hit;
  logic [7:0]    byp_data;
  logic [7:0]    dst;
  logic [7:0]    blended;

  function automatic logic [7:0] blend(logic [1:0] mode, logic [7:0] s, logic [7:0] d);
    logic [4:0] sum;
    logic [7:0] v;
    sum = {1'b0, s[3:0]} + {1'b0, d[3:0]};
    case (mode)
      MODE_AVG:    v = {s[7:4], sum[4:1]};
      MODE_SHADOW: v = {d[7:4], 1'b0, d[3:1]};
      default:     v = s;
    endcase
    return v;
  endfunction

  assign load    = adv || !s1_valid;
  assign rd_en   = load && req.valid && (req.kind == KIND_PIXEL);
  assign rd_addr = req.addr[AW-1:0];

  // a write landing on the same edge as the read is picked up here
  assign dst     = byp_hit ? byp_data : rdata;
  assign blended = blend(s1_mode, s1_src, dst);

  assign wr_en   = clearing || (s1_valid && adv && (s1_kind == KIND_PIXEL));
  assign wr_addr = clearing ? clr_cnt : s1_addr;
  assign wr_data = clearing ? 8'h00 : blended;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else if (load) begin
      s1_valid <= req.valid;
      byp_hit  <= rd_en && wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_kind  <= req.kind;
      s1_mode  <= req.mode;
      s1_src   <= req.src;
      s1_addr  <= rd_addr;
      byp_data <= wr_data;
    end
  end

  always_comb begin
    res.kind  = s1_kind;
    res.addr  = '0;
    res.value = '0;
    if (s1_kind == KIND_PIXEL) begin
      res.addr  = 16'(s1_addr);
      res.value = blended;
    end
  end

`ifndef SYNTHESIS
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid)
    else $error("result pending during clearing pass");

  a_bypass_only_pixel: assert property (@(posedge clk) disable iff (rst)
    byp_hit |-> (s1_valid && (s1_kind == KIND_PIXEL)))
    else $error("bypass flagged without a pixel in flight");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clr_cnt) == LAST_ADDR))
    else $error("clearing pass ended early");
`endif

endmodule

// File: rtl/core/rle_sprite_blitter.sv
// Run-length sprite blitter into an on-chip 8-bit framebuffer of
// SCREEN_WIDTH x SCREEN_HEIGHT bytes. After reset the framebuffer is swept to
// zero, one byte a cycle, over all SCREEN_WIDTH * SCREEN_HEIGHT bytes (64000
// at the default size); s_tready stays low during that sweep. Afterwards one
// item is taken every cycle while the m side does not stall: each pixel byte
// inside the buffer costs one read-modify-write of the framebuffer through its
// one read port and one write port, and a write on the same edge as the
// following read is forwarded. A result passes the framebuffer stage and
// then the output register, which lets the next item in while a result waits.
module rle_sprite_blitter #(
  parameter int SCREEN_WIDTH  = rsb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = rsb_pkg::DEF_SCREEN_HEIGHT,
  parameter int ROW_BACKSTEP  = rsb_pkg::DEF_ROW_BACKSTEP
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // start_x[10:0], start_y[21:11], blend_mode[23:22], code_byte[31:24]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pixel_address[15:0], pixel_value[23:16]
  output logic [1:0]  m_tuser    // result_kind
);
  import rsb_pkg::*;

  localparam pos_t FB_END   = pos_t'(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam pos_t ROW_STEP = pos_t'(SCREEN_WIDTH - ROW_BACKSTEP);
  localparam pos_t WIDTH_P  = pos_t'(SCREEN_WIDTH);

  logic              accept;
  logic              adv;
  logic              s1_valid;
  logic              clearing;
  req_t              req;
  res_t              res;

  logic signed [10:0] start_x;
  logic signed [10:0] start_y;
  logic [1:0]         blend_mode;
  logic [7:0]         code_byte;

  pos_t       pos, pos_next;
  logic [3:0] run_left, run_left_next;
  logic       in_run, in_run_next;
  logic       active, active_next;
  logic [1:0] cur_mode, cur_mode_next;
  pos_t       row_base;
  pos_t       skip_pos;

  assign start_x    = s_tdata[10:0];
  assign start_y    = s_tdata[21:11];
  assign blend_mode = s_tdata[23:22];
  assign code_byte  = s_tdata[31:24];

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !clearing && (!s1_valid || adv);
  assign accept   = s_tvalid && s_tready;

  assign row_base = pos_t'(start_y) * WIDTH_P;
  assign skip_pos = pos_add(pos, pos_t'(code_byte[3:0]));

  always_comb begin
    pos_next      = pos;
    run_left_next = run_left;
    in_run_next   = in_run;
    active_next   = active;
    cur_mode_next = cur_mode;
    req           = '0;
    if (accept) begin
      if (s_tuser == OP_START) begin
        pos_next      = pos_add(row_base, pos_t'(start_x));
        cur_mode_next = blend_mode;
        run_left_next = '0;
        in_run_next   = 1'b0;
        active_next   = 1'b1;
      end else if (active) begin
        if (in_run) begin
          if (pos >= FB_END) begin
            active_next   = 1'b0;
            in_run_next   = 1'b0;
            run_left_next = '0;
            req.valid     = 1'b1;
            req.kind      = KIND_ABORT;
          end else begin
            // pixels before the buffer still step the position
            if (!pos[POS_W-1]) begin
              req.valid = 1'b1;
              req.kind  = KIND_PIXEL;
              req.mode  = cur_mode;
              req.src   = code_byte;
              req.addr  = ADDR_W'(pos);
            end
            pos_next      = pos_add(pos, pos_t'(1));
            run_left_next = run_left - 4'd1;
            if (run_left_next == 4'd0) begin
              in_run_next = 1'b0;
            end
          end
        end else if (code_byte == END_MARK) begin
          active_next = 1'b0;
          req.valid   = 1'b1;
          req.kind    = KIND_DONE;
        end else begin
          run_left_next = code_byte[7:4];
          if (code_byte[7:4] == 4'd0) begin
            pos_next = pos_add(skip_pos, ROW_STEP);
          end else begin
            pos_next    = skip_pos;
            in_run_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      run_left <= '0;
      in_run   <= 1'b0;
      active   <= 1'b0;
      cur_mode <= MODE_COPY;
    end else begin
      pos      <= pos_next;
      run_left <= run_left_next;
      in_run   <= in_run_next;
      active   <= active_next;
      cur_mode <= cur_mode_next;
    end
  end

  rsb_frame #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .adv      (adv),
    .s1_valid (s1_valid),
    .res      (res),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {res.value, res.addr};
      m_tuser <= res.kind;
    end
  end

`ifndef SYNTHESIS
  a_run_needs_sprite: assert property (@(posedge clk) disable iff (rst)
    in_run |-> active)
    else $error("pixel run outside an active sprite");

  a_run_count_live: assert property (@(posedge clk) disable iff (rst)
    in_run |-> (run_left != 4'd0))
    else $error("pixel run with nothing left");

  a_status_no_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tuser == KIND_DONE) || (m_tuser == KIND_ABORT))) |-> (m_tdata == 24'd0))
    else $error("finish or abort item carries pixel data");
`endif

endmodule
